[rtl/lsts_pkg.sv]
// ----------------------------------------------------------------------------
// Link setup/teardown sender - shared definitions
// Request, action and phase codes, frame length and register reset values.
// ----------------------------------------------------------------------------
package lsts_pkg;

  // Request codes carried by req_type
  localparam logic [1:0] REQ_RX_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_OPEN    = 2'd2;
  localparam logic [1:0] REQ_CLOSE   = 2'd3;

  // Result action codes
  localparam logic [2:0] ACT_SET        = 3'd0;
  localparam logic [2:0] ACT_DISC       = 3'd1;
  localparam logic [2:0] ACT_UA_CLOSED  = 3'd2;
  localparam logic [2:0] ACT_CONNECTED  = 3'd3;
  localparam logic [2:0] ACT_OPEN_FAIL  = 3'd4;
  localparam logic [2:0] ACT_CLOSE_FAIL = 3'd5;

  // Link phase codes
  localparam logic [1:0] PH_IDLE          = 2'd0;
  localparam logic [1:0] PH_CONNECTING    = 2'd1;
  localparam logic [1:0] PH_TRANSFERRING  = 2'd2;
  localparam logic [1:0] PH_DISCONNECTING = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_FLAG_BYTE      = 3'd0;
  localparam logic [2:0] CFG_OPEN_ADDR      = 3'd1;
  localparam logic [2:0] CFG_UA_CTRL        = 3'd2;
  localparam logic [2:0] CFG_CLOSE_ADDR     = 3'd3;
  localparam logic [2:0] CFG_DISC_CTRL      = 3'd4;
  localparam logic [2:0] CFG_OPEN_LIMIT     = 3'd5;
  localparam logic [2:0] CFG_CLOSE_LIMIT    = 3'd6;
  localparam logic [2:0] CFG_TIMEOUT_TICKS  = 3'd7;

  // Reply frame: flag, address, control, BCC, flag
  localparam int unsigned FRAME_LEN = 5;
  localparam logic [2:0] MATCH_FLAG_OPEN  = 3'd0;
  localparam logic [2:0] MATCH_ADDR       = 3'd1;
  localparam logic [2:0] MATCH_CTRL       = 3'd2;
  localparam logic [2:0] MATCH_BCC        = 3'd3;
  localparam logic [2:0] MATCH_FLAG_CLOSE = 3'd4;

  // Register reset values
  localparam logic [7:0]  RST_FLAG_BYTE     = 8'd126;
  localparam logic [7:0]  RST_OPEN_ADDR     = 8'd3;
  localparam logic [7:0]  RST_UA_CTRL       = 8'd7;
  localparam logic [7:0]  RST_CLOSE_ADDR    = 8'd1;
  localparam logic [7:0]  RST_DISC_CTRL     = 8'd11;
  localparam logic [3:0]  RST_OPEN_LIMIT    = 4'd3;
  localparam logic [3:0]  RST_CLOSE_LIMIT   = 4'd4;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3;

endpackage

[rtl/link_setup_teardown_sender_unit.sv]
// ----------------------------------------------------------------------------
// Link setup/teardown sender unit
// Sender side of a serial link: opens and closes a connection with retries.
// ----------------------------------------------------------------------------
//
// Each item on the input channel is a received byte, a timer tick, an open
// command or a close command. An open sends SET and waits for the UA frame
// (flag, address, control, address XOR control, flag); a close sends DISC
// and waits for the peer's DISC frame, then answers with UA. A byte that
// does not fit the frame position sends the match back to the start, and
// that byte is not retried as a new start. Ticks count toward a timeout;
// each timeout raises the attempt count and either resends or gives up once
// the attempt limit is passed. Commands are honored in any phase and restart
// the exchange. Bytes and ticks while idle or transferring make no result.
// An item produces zero or one result item carrying the action and the
// phase after the step. Rate: one item per cycle while results are claimed;
// an item goes from the input register through one pass of compare and
// counter logic into the result register, which presents its result.
// Input is held back only while a result sits unclaimed in the result
// register. Configuration is written through its own port, one register
// per write, and is taken in any cycle; write it only while the unit is idle.
//
module link_setup_teardown_sender_unit
  import lsts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [1:0]  link_phase_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  flag_byte_q;
  logic [7:0]  open_addr_q;
  logic [7:0]  ua_ctrl_q;
  logic [7:0]  close_addr_q;
  logic [7:0]  disc_ctrl_q;
  logic [3:0]  open_limit_q;
  logic [3:0]  close_limit_q;
  logic [15:0] timeout_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_byte_q     <= RST_FLAG_BYTE;
      open_addr_q     <= RST_OPEN_ADDR;
      ua_ctrl_q       <= RST_UA_CTRL;
      close_addr_q    <= RST_CLOSE_ADDR;
      disc_ctrl_q     <= RST_DISC_CTRL;
      open_limit_q    <= RST_OPEN_LIMIT;
      close_limit_q   <= RST_CLOSE_LIMIT;
      timeout_ticks_q <= RST_TIMEOUT_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FLAG_BYTE:     flag_byte_q     <= cfg_data_i[7:0];
        CFG_OPEN_ADDR:     open_addr_q     <= cfg_data_i[7:0];
        CFG_UA_CTRL:       ua_ctrl_q       <= cfg_data_i[7:0];
        CFG_CLOSE_ADDR:    close_addr_q    <= cfg_data_i[7:0];
        CFG_DISC_CTRL:     disc_ctrl_q     <= cfg_data_i[7:0];
        CFG_OPEN_LIMIT:    open_limit_q    <= cfg_data_i[3:0];
        CFG_CLOSE_LIMIT:   close_limit_q   <= cfg_data_i[3:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and stage control
  // --------------------------------------------------------------------------
  logic       in_valid_q;
  logic [1:0] req_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       advance;

  // Process the held item whenever the result slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; load only on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= req_type_i;
      byte_q <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Link state
  // --------------------------------------------------------------------------
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  match_q, match_d;
  logic [3:0]  attempt_q, attempt_d;
  logic [15:0] timer_q, timer_d;

  logic        res_valid;
  logic [2:0]  res_action;

  // Combinational helpers
  logic        opening, closing;
  logic [7:0]  exp_addr, exp_ctrl, exp_byte;
  logic        hit;
  logic [2:0]  match_inc;
  logic [15:0] limit_t;
  logic [16:0] timer_inc;
  logic [4:0]  attempt_inc;
  logic [3:0]  cur_limit;

  assign opening = (phase_q == PH_CONNECTING);
  assign closing = (phase_q == PH_DISCONNECTING);

  // Pick the frame being awaited in this phase.
  assign exp_addr = opening ? open_addr_q : close_addr_q;
  assign exp_ctrl = opening ? ua_ctrl_q   : disc_ctrl_q;
  assign cur_limit = opening ? open_limit_q : close_limit_q;

  always_comb begin
    exp_byte = flag_byte_q;
    hit      = 1'b0;
    case (match_q)
      MATCH_FLAG_OPEN: begin
        exp_byte = flag_byte_q;
        hit      = (byte_q == exp_byte);
      end
      MATCH_ADDR: begin
        exp_byte = exp_addr;
        hit      = (byte_q == exp_byte);
      end
      MATCH_CTRL: begin
        exp_byte = exp_ctrl;
        hit      = (byte_q == exp_byte);
      end
      MATCH_BCC: begin
        exp_byte = exp_addr ^ exp_ctrl;
        hit      = (byte_q == exp_byte);
      end
      MATCH_FLAG_CLOSE: begin
        exp_byte = flag_byte_q;
        hit      = (byte_q == exp_byte);
      end
      default: begin
        exp_byte = flag_byte_q;
        hit      = 1'b0;
      end
    endcase
  end

  assign match_inc   = match_q + 3'd1;
  // A zero timeout counts as one tick.
  assign limit_t     = (timeout_ticks_q == 16'd0) ? 16'd1 : timeout_ticks_q;
  assign timer_inc   = {1'b0, timer_q} + 17'd1;
  assign attempt_inc = {1'b0, attempt_q} + 5'd1;

  always_comb begin
    phase_d    = phase_q;
    match_d    = match_q;
    attempt_d  = attempt_q;
    timer_d    = timer_q;
    res_valid  = 1'b0;
    res_action = ACT_SET;

    case (req_q)
      REQ_OPEN: begin
        // Restart connecting from the first attempt.
        attempt_d = 4'd1;
        match_d   = MATCH_FLAG_OPEN;
        timer_d   = '0;
        res_valid = 1'b1;
        if (open_limit_q == 4'd0) begin
          phase_d    = PH_IDLE;
          res_action = ACT_OPEN_FAIL;
        end else begin
          phase_d    = PH_CONNECTING;
          res_action = ACT_SET;
        end
      end
      REQ_CLOSE: begin
        attempt_d = 4'd1;
        match_d   = MATCH_FLAG_OPEN;
        timer_d   = '0;
        res_valid = 1'b1;
        if (close_limit_q == 4'd0) begin
          phase_d    = PH_IDLE;
          res_action = ACT_CLOSE_FAIL;
        end else begin
          phase_d    = PH_DISCONNECTING;
          res_action = ACT_DISC;
        end
      end
      REQ_RX_BYTE: begin
        if (opening || closing) begin
          if (!hit) begin
            // Drop back to the frame start; this byte is not rechecked.
            match_d = MATCH_FLAG_OPEN;
          end else if (match_inc == 3'(FRAME_LEN)) begin
            match_d   = MATCH_FLAG_OPEN;
            timer_d   = '0;
            res_valid = 1'b1;
            if (opening) begin
              phase_d    = PH_TRANSFERRING;
              res_action = ACT_CONNECTED;
            end else begin
              phase_d    = PH_IDLE;
              res_action = ACT_UA_CLOSED;
            end
          end else begin
            match_d = match_inc;
          end
        end
      end
      REQ_TICK: begin
        if (opening || closing) begin
          if (timer_inc < {1'b0, limit_t}) begin
            timer_d = timer_inc[15:0];
          end else begin
            // Timeout: clear the frame match and either resend or give up.
            timer_d   = '0;
            match_d   = MATCH_FLAG_OPEN;
            res_valid = 1'b1;
            if (attempt_inc > {1'b0, cur_limit}) begin
              phase_d    = PH_IDLE;
              res_action = opening ? ACT_OPEN_FAIL : ACT_CLOSE_FAIL;
            end else begin
              attempt_d  = attempt_inc[3:0];
              res_action = opening ? ACT_SET : ACT_DISC;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      match_q   <= MATCH_FLAG_OPEN;
      attempt_q <= 4'd1;
      timer_q   <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      match_q   <= match_d;
      attempt_q <= attempt_d;
      timer_q   <= timer_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [2:0] action_q;
  logic [1:0] out_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      action_q    <= res_action;
      out_phase_q <= phase_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign link_phase_o = out_phase_q;

endmodule

[rtl/lsts_checker.sv]
// ----------------------------------------------------------------------------
// Link setup/teardown sender - port checker
// Watches the unit's ports and checks results and the result handshake.
// ----------------------------------------------------------------------------
module lsts_checker
  import lsts_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] action_o,
  input logic [1:0] link_phase_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) && $stable(link_phase_o))
    else $error("result changed while stalled");

  // A completed open leaves the link transferring.
  a_connected_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_CONNECTED |-> link_phase_o == PH_TRANSFERRING)
    else $error("connected result without transferring phase");

  // Failures and a finished close leave the link idle.
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_OPEN_FAIL || action_o == ACT_CLOSE_FAIL ||
                    action_o == ACT_UA_CLOSED) |-> link_phase_o == PH_IDLE)
    else $error("terminal result without idle phase");

  // A SET goes out only while connecting, a DISC only while disconnecting.
  a_send_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o != ACT_SET || link_phase_o == PH_CONNECTING) &&
                    (action_o != ACT_DISC || link_phase_o == PH_DISCONNECTING))
    else $error("send result in the wrong phase");

endmodule

bind link_setup_teardown_sender_unit lsts_checker u_lsts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .action_o     (action_o),
  .link_phase_o (link_phase_o)
);
